// ----- rtl/tlv8_pkg.sv -----
// tlv8_pkg: shared types and constants of the tlv8 stream decoder
// item, result and command structs, result kinds, length limits
// no dependencies
`default_nettype none

package tlv8_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

	localparam logic [7:0] FULL_FRAGMENT = 8'd255;

	localparam logic [1:0] KIND_VALUE = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  item_type;
		logic [7:0]  value_byte;
		logic [15:0] item_length;
	} out_item_t;

	// one front decision: a first result, optionally followed by an item end
	typedef struct packed {
		out_item_t res;
		logic      then_end;
	} cmd_t;

	typedef struct packed {
		logic wr_en;
		cmd_t cmd;
	} cmdq_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cmdq_status_t;

endpackage

`default_nettype wire

// ----- rtl/tlv8_stream_decoder.sv -----
// tlv8_stream_decoder: top level of the tlv8 stream decoder
// front parser, command queue and result expander
// depends on tlv8_pkg, tlv8_front, tlv8_cmdq, tlv8_back
//
// input side is a queue: drive item and push, an item is taken at an edge
// where push is high and full is low. item.op low carries one stream byte,
// item.op high marks end of stream and returns the parser to its idle state.
// result side is a queue too: while empty is low the oldest result is on
// result, and it is taken at an edge where pop is high.
// each value byte gives one result; the last byte of a fragment shorter than
// 255 bytes gives a value result and an item end result; type and length
// bytes and end of stream give at most one result.
// one item per cycle is taken while full is low; the result expander puts out
// one result per cycle while pop is high, so an item with two results gives them one after the other.
// first result of an item passes through the command queue and then the output register.
// a stalled receiver fills the four-entry command queue, after which full
// rises and the input waits; nothing is lost.
// reset clears the parser state, the queue and the output valid and pending end flags.
`default_nettype none

module tlv8_stream_decoder (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  tlv8_pkg::in_item_t   item,
	output logic                 empty,
	input  wire                  pop,
	output tlv8_pkg::out_item_t  result
);

	tlv8_pkg::cmdq_wr_t      q_wr;
	tlv8_pkg::cmdq_status_t  q_status;
	tlv8_pkg::cmd_t          q_head;
	logic                    q_rd_en;

	assign full = q_status.full;

	tlv8_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (q_status.full),
		.q_wr   (q_wr)
	);

	tlv8_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.rd_en  (q_rd_en),
		.rd_cmd (q_head),
		.status (q_status)
	);

	tlv8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_status (q_status),
		.rd_en    (q_rd_en),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire

// ----- rtl/tlv8_front.sv -----
// tlv8_front: accepts stream items and runs the tlv8 parse state
// emits at most one command per item into the command queue
// depends on tlv8_pkg
`default_nettype none

module tlv8_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  tlv8_pkg::in_item_t      item,
	input  wire                     q_full,
	output tlv8_pkg::cmdq_wr_t      q_wr
);

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN  = 2'd1,
		PH_VAL  = 2'd2
	} phase_t;

	localparam logic [tlv8_pkg::CNT_W-1:0] LEN_CAP = '1;

	phase_t                      phase_q, phase_d;
	logic                        item_open_q, item_open_d;
	logic [7:0]                  current_type_q, current_type_d;
	logic [7:0]                  fragment_left_q, fragment_left_d;
	logic                        fragment_full_q, fragment_full_d;
	logic [tlv8_pkg::CNT_W-1:0]  item_count_q, item_count_d;
	logic [tlv8_pkg::CNT_W-1:0]  count_inc;
	logic [7:0]                  left_dec;
	logic                        accept;

	assign accept = push && !q_full;
	assign count_inc = (item_count_q != LEN_CAP) ? item_count_q + 1'b1 : item_count_q;
	assign left_dec = (fragment_left_q != 8'd0) ? fragment_left_q - 8'd1 : 8'd0;

	always_comb begin
		phase_d = phase_q;
		item_open_d = item_open_q;
		current_type_d = current_type_q;
		fragment_left_d = fragment_left_q;
		fragment_full_d = fragment_full_q;
		item_count_d = item_count_q;
		q_wr.wr_en = 1'b0;
		q_wr.cmd.then_end = 1'b0;
		q_wr.cmd.res.kind = tlv8_pkg::KIND_END;
		q_wr.cmd.res.item_type = current_type_q;
		q_wr.cmd.res.value_byte = 8'd0;
		q_wr.cmd.res.item_length = 16'(item_count_q);
		if (accept) begin
			if (item.op) begin
				if (phase_q == PH_LEN || phase_q == PH_VAL) begin
					q_wr.wr_en = 1'b1;
					q_wr.cmd.res.kind = tlv8_pkg::KIND_TRUNC;
				end else begin
					q_wr.wr_en = item_open_q;
				end
				phase_d = PH_TYPE;
				item_open_d = 1'b0;
				fragment_left_d = 8'd0;
				fragment_full_d = 1'b0;
				item_count_d = '0;
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						if (item.data_byte == 8'd0) begin
							q_wr.wr_en = 1'b1;
							phase_d = PH_TYPE;
							item_open_d = 1'b0;
							fragment_left_d = 8'd0;
							fragment_full_d = 1'b0;
							item_count_d = '0;
						end else begin
							fragment_left_d = item.data_byte;
							fragment_full_d = (item.data_byte == tlv8_pkg::FULL_FRAGMENT);
							phase_d = PH_VAL;
						end
					end
					PH_VAL: begin
						q_wr.wr_en = 1'b1;
						q_wr.cmd.res.kind = tlv8_pkg::KIND_VALUE;
						q_wr.cmd.res.value_byte = item.data_byte;
						q_wr.cmd.res.item_length = 16'(count_inc);
						item_count_d = count_inc;
						fragment_left_d = left_dec;
						if (left_dec == 8'd0) begin
							if (fragment_full_q) begin
								phase_d = PH_TYPE;
							end else begin
								q_wr.cmd.then_end = 1'b1;
								phase_d = PH_TYPE;
								item_open_d = 1'b0;
								fragment_full_d = 1'b0;
								item_count_d = '0;
							end
						end
					end
					default: begin
						// type byte, also covers the unused phase code
						if (item_open_q && fragment_full_q
								&& item.data_byte == current_type_q) begin
							fragment_full_d = 1'b0;
						end else begin
							q_wr.wr_en = item_open_q;
							current_type_d = item.data_byte;
							item_count_d = '0;
							item_open_d = 1'b1;
							fragment_full_d = 1'b0;
						end
						phase_d = PH_LEN;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			item_open_q <= 1'b0;
			current_type_q <= 8'd0;
			fragment_left_q <= 8'd0;
			fragment_full_q <= 1'b0;
			item_count_q <= '0;
		end else begin
			phase_q <= phase_d;
			item_open_q <= item_open_d;
			current_type_q <= current_type_d;
			fragment_left_q <= fragment_left_d;
			fragment_full_q <= fragment_full_d;
			item_count_q <= item_count_d;
		end
	end

	a_val_open: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VAL |-> item_open_q && fragment_left_q != 8'd0)
		else $error("value phase without open item or bytes due");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr.wr_en)
		else $error("command written while queue full");

endmodule

`default_nettype wire

// ----- rtl/tlv8_cmdq.sv -----
// tlv8_cmdq: short command queue between front and back
// small register array with read and write pointers and an entry count
// depends on tlv8_pkg
`default_nettype none

module tlv8_cmdq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tlv8_pkg::cmdq_wr_t      wr,
	input  wire                     rd_en,
	output tlv8_pkg::cmd_t          rd_cmd,
	output tlv8_pkg::cmdq_status_t  status
);

	tlv8_pkg::cmd_t                 mem_q [tlv8_pkg::CMDQ_DEPTH];
	logic [tlv8_pkg::CMDQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [tlv8_pkg::CMDQ_CW-1:0]   count_q;
	logic                           do_wr, do_rd;

	localparam logic [tlv8_pkg::CMDQ_AW-1:0] LAST = tlv8_pkg::CMDQ_AW'(tlv8_pkg::CMDQ_DEPTH - 1);
	localparam logic [tlv8_pkg::CMDQ_CW-1:0] DEPTH_C = tlv8_pkg::CMDQ_CW'(tlv8_pkg::CMDQ_DEPTH);

	assign status.full = (count_q == DEPTH_C);
	assign status.empty = (count_q == '0);
	assign do_wr = wr.wr_en && !status.full;
	assign do_rd = rd_en && !status.empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/tlv8_back.sv -----
// tlv8_back: expands queued commands into result items
// holds the output register and a pending item end flag
// depends on tlv8_pkg
`default_nettype none

module tlv8_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tlv8_pkg::cmd_t          head,
	input  tlv8_pkg::cmdq_status_t  q_status,
	output logic                    rd_en,
	input  wire                     pop,
	output logic                    empty,
	output tlv8_pkg::out_item_t     result
);

	tlv8_pkg::out_item_t  out_q;
	logic                 out_valid_q;
	logic                 pending_end_q;
	logic                 load;

	assign load = !out_valid_q || pop;
	assign rd_en = load && !pending_end_q && !q_status.empty;
	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pending_end_q <= 1'b0;
		end else if (load) begin
			if (pending_end_q) begin
				out_valid_q <= 1'b1;
				pending_end_q <= 1'b0;
			end else if (!q_status.empty) begin
				out_valid_q <= 1'b1;
				pending_end_q <= head.then_end;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item end after the last value byte keeps type and length
	always_ff @(posedge clk) begin
		if (load) begin
			if (pending_end_q) begin
				out_q.kind <= tlv8_pkg::KIND_END;
				out_q.value_byte <= 8'd0;
			end else if (!q_status.empty) begin
				out_q <= head.res;
			end
		end
	end

	a_pending_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pending_end_q |-> out_valid_q)
		else $error("pending item end without a held result");

endmodule

`default_nettype wire
